// ----- hdl/quaternion_vector_rotate_top_defines.svh -----
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// Same-cycle implication, reset-gated.
`define QVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset-gated.
`define QVR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

    localparam int DATA_W        = 16;
    localparam int FRAC_BITS_DEF = 14;

    typedef logic signed [DATA_W-1:0] sample_t;

endpackage

// ----- hdl/qvr_in_if.sv -----
`timescale 1ns / 1ps

interface qvr_in_if
    import qvr_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t quat_w;
    sample_t quat_x;
    sample_t quat_y;
    sample_t quat_z;
    sample_t vec_x;
    sample_t vec_y;
    sample_t vec_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

// ----- hdl/qvr_out_if.sv -----
`timescale 1ns / 1ps

interface qvr_out_if
    import qvr_pkg::*;
;
    logic    valid;
    logic    ready;
    sample_t out_x;
    sample_t out_y;
    sample_t out_z;
    logic    saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

// ----- hdl/quaternion_vector_rotate_top.sv -----
`timescale 1ns / 1ps

// Rotates a vector by a quaternion, r = q * (0,v) * conj(q), one word per clock in
// and out. Four register stages (q*v products, first sum and shift, t*conj(q)
// products, second sum, shift and clamp) carry each word from input to output;
// each stage holds its word under back-pressure and fills bubbles, so with no
// back-pressure the sustained rate is one word per cycle. The quaternion is used as
// given, without normalization; results are clamped to 16 bits and flagged.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    qvr_in_if.sink     vin,
    qvr_out_if.source  vout
);

    localparam int PROD1_W = 2 * DATA_W;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int T_W     = SUM1_W - FRAC_BITS;
    localparam int PROD2_W = T_W + DATA_W;
    localparam int SUM2_W  = PROD2_W + 2;

    typedef logic signed [PROD1_W-1:0] prod1_t;
    typedef logic signed [SUM1_W-1:0]  sum1_t;
    typedef logic signed [T_W-1:0]     tcomp_t;
    typedef logic signed [PROD2_W-1:0] prod2_t;
    typedef logic signed [SUM2_W-1:0]  sum2_t;

    localparam sum2_t R_MAX = SUM2_W'(2 ** (DATA_W - 1) - 1);
    localparam sum2_t R_MIN = SUM2_W'(-(2 ** (DATA_W - 1)));

    function automatic prod1_t mul1(sample_t a, sample_t b);
        return prod1_t'(a) * prod1_t'(b);
    endfunction

    function automatic prod2_t mul2(tcomp_t a, sample_t b);
        return prod2_t'(a) * prod2_t'(b);
    endfunction

    // Stage valid bits and advance enables
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic adv1, adv2, adv3, adv4;

    // Stage 1: q * v products, quaternion carried along
    prod1_t  p1_reg  [4][3];
    prod1_t  p1_next [4][3];
    sample_t q1_reg  [4];

    // Stage 2: t components
    sum1_t   s1_sum  [4];
    tcomp_t  t2_reg  [4];
    tcomp_t  t2_next [4];
    sample_t q2_reg  [4];

    // Stage 3: t * conj(q) products
    prod2_t  p3_reg  [3][4];
    prod2_t  p3_next [3][4];

    // Stage 4: rotated vector
    sum2_t   s2_sum  [3];
    sum2_t   s2_shf  [3];
    sample_t r_next  [3];
    logic    sat_next;
    sample_t r_reg   [3];
    logic    sat_reg;

    assign adv4 = !s4_vld_reg || vout.ready;
    assign adv3 = !s3_vld_reg || adv4;
    assign adv2 = !s2_vld_reg || adv3;
    assign adv1 = !s1_vld_reg || adv2;

    assign vin.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_vld_reg <= vin.valid;
            end
            if (adv2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (adv3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (adv4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    always_comb
    begin
        p1_next[0][0] = mul1(vin.quat_x, vin.vec_x);
        p1_next[0][1] = mul1(vin.quat_y, vin.vec_y);
        p1_next[0][2] = mul1(vin.quat_z, vin.vec_z);
        p1_next[1][0] = mul1(vin.quat_w, vin.vec_x);
        p1_next[1][1] = mul1(vin.quat_y, vin.vec_z);
        p1_next[1][2] = mul1(vin.quat_z, vin.vec_y);
        p1_next[2][0] = mul1(vin.quat_w, vin.vec_y);
        p1_next[2][1] = mul1(vin.quat_x, vin.vec_z);
        p1_next[2][2] = mul1(vin.quat_z, vin.vec_x);
        p1_next[3][0] = mul1(vin.quat_w, vin.vec_z);
        p1_next[3][1] = mul1(vin.quat_x, vin.vec_y);
        p1_next[3][2] = mul1(vin.quat_y, vin.vec_x);
    end

    always_comb
    begin
        s1_sum[0] = -(sum1_t'(p1_reg[0][0]) + sum1_t'(p1_reg[0][1]) + sum1_t'(p1_reg[0][2]));
        s1_sum[1] = sum1_t'(p1_reg[1][0]) + sum1_t'(p1_reg[1][1]) - sum1_t'(p1_reg[1][2]);
        s1_sum[2] = sum1_t'(p1_reg[2][0]) - sum1_t'(p1_reg[2][1]) + sum1_t'(p1_reg[2][2]);
        s1_sum[3] = sum1_t'(p1_reg[3][0]) + sum1_t'(p1_reg[3][1]) - sum1_t'(p1_reg[3][2]);
        for (int k = 0; k < 4; k++)
        begin
            t2_next[k] = T_W'(s1_sum[k] >>> FRAC_BITS);
        end
    end

    // q2_reg holds w, x, y, z in that order
    always_comb
    begin
        p3_next[0][0] = mul2(t2_reg[1], q2_reg[0]);
        p3_next[0][1] = mul2(t2_reg[0], q2_reg[1]);
        p3_next[0][2] = mul2(t2_reg[2], q2_reg[3]);
        p3_next[0][3] = mul2(t2_reg[3], q2_reg[2]);
        p3_next[1][0] = mul2(t2_reg[2], q2_reg[0]);
        p3_next[1][1] = mul2(t2_reg[0], q2_reg[2]);
        p3_next[1][2] = mul2(t2_reg[1], q2_reg[3]);
        p3_next[1][3] = mul2(t2_reg[3], q2_reg[1]);
        p3_next[2][0] = mul2(t2_reg[3], q2_reg[0]);
        p3_next[2][1] = mul2(t2_reg[0], q2_reg[3]);
        p3_next[2][2] = mul2(t2_reg[1], q2_reg[2]);
        p3_next[2][3] = mul2(t2_reg[2], q2_reg[1]);
    end

    always_comb
    begin
        s2_sum[0] = sum2_t'(p3_reg[0][0]) - sum2_t'(p3_reg[0][1])
                  - sum2_t'(p3_reg[0][2]) + sum2_t'(p3_reg[0][3]);
        s2_sum[1] = sum2_t'(p3_reg[1][0]) - sum2_t'(p3_reg[1][1])
                  + sum2_t'(p3_reg[1][2]) - sum2_t'(p3_reg[1][3]);
        s2_sum[2] = sum2_t'(p3_reg[2][0]) - sum2_t'(p3_reg[2][1])
                  - sum2_t'(p3_reg[2][2]) + sum2_t'(p3_reg[2][3]);
        sat_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            s2_shf[k] = s2_sum[k] >>> FRAC_BITS;
            priority if (s2_shf[k] > R_MAX)
            begin
                r_next[k] = sample_t'(R_MAX);
                sat_next  = 1'b1;
            end
            else if (s2_shf[k] < R_MIN)
            begin
                r_next[k] = sample_t'(R_MIN);
                sat_next  = 1'b1;
            end
            else
            begin
                r_next[k] = sample_t'(s2_shf[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && vin.valid)
        begin
            p1_reg    <= p1_next;
            q1_reg[0] <= vin.quat_w;
            q1_reg[1] <= vin.quat_x;
            q1_reg[2] <= vin.quat_y;
            q1_reg[3] <= vin.quat_z;
        end
        if (adv2 && s1_vld_reg)
        begin
            t2_reg <= t2_next;
            q2_reg <= q1_reg;
        end
        if (adv3 && s2_vld_reg)
        begin
            p3_reg <= p3_next;
        end
        if (adv4 && s3_vld_reg)
        begin
            r_reg   <= r_next;
            sat_reg <= sat_next;
        end
    end

    assign vout.valid     = s4_vld_reg;
    assign vout.out_x     = r_reg[0];
    assign vout.out_y     = r_reg[1];
    assign vout.out_z     = r_reg[2];
    assign vout.saturated = sat_reg;

endmodule

// ----- hdl/qvr_checker.sv -----
`timescale 1ns / 1ps

`include "quaternion_vector_rotate_top_defines.svh"

module qvr_checker
    import qvr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input sample_t quat_w,
    input sample_t quat_x,
    input sample_t quat_y,
    input sample_t quat_z,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_x,
    input sample_t out_y,
    input sample_t out_z,
    input logic    saturated
);

    localparam sample_t S_MAX = sample_t'(2 ** (DATA_W - 1) - 1);
    localparam sample_t S_MIN = sample_t'(-(2 ** (DATA_W - 1)));

    logic in_acc;
    logic quat_zero;
    logic out_stall;
    logic out_sat;
    logic out_rail;
    logic out_zero;

    assign in_acc    = in_valid && in_ready;
    assign quat_zero = (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
    assign out_stall = out_valid && !out_ready;
    assign out_sat   = out_valid && saturated;
    assign out_rail  = (out_x == S_MAX) || (out_x == S_MIN)
                    || (out_y == S_MAX) || (out_y == S_MIN)
                    || (out_z == S_MAX) || (out_z == S_MIN);
    assign out_zero  = (out_x == '0) && (out_y == '0) && (out_z == '0) && !saturated;

    sequence acc_run;
        in_acc ##1 out_ready [*3];
    endsequence

    sequence zero_run;
        (in_acc && quat_zero) ##1 out_ready [*3];
    endsequence

    `QVR_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid, "word dropped while stalled")

    `QVR_ASSERT_NXT(a_latency, clk, rst_n, acc_run, out_valid, "word late after accept")

    `QVR_ASSERT_IMP(a_sat_rail, clk, rst_n, out_sat, out_rail, "saturated flag without a clamp")

    `QVR_ASSERT_NXT(a_zero_quat, clk, rst_n, zero_run, out_zero, "zero quaternion not zero")

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vin.valid),
    .in_ready  (vin.ready),
    .quat_w    (vin.quat_w),
    .quat_x    (vin.quat_x),
    .quat_y    (vin.quat_y),
    .quat_z    (vin.quat_z),
    .out_valid (vout.valid),
    .out_ready (vout.ready),
    .out_x     (vout.out_x),
    .out_y     (vout.out_y),
    .out_z     (vout.out_z),
    .saturated (vout.saturated)
);
